[design/lr_pkg.sv]
`timescale 1ns / 1ps

package lr_pkg;

  // Stepping controls handed from the classifier to the pixel stepper.
  typedef struct packed {
    logic y_moves;
    logic x_moves;
    logic y_down;
    logic x_down;
    logic swapped;
  } lr_flags_t;

endpackage

[design/lr_front.sv]
`timescale 1ns / 1ps

module lr_front #(
  parameter int COORD_BITS = 6
) (
  input  logic [COORD_BITS-1:0]   start_x,
  input  logic [COORD_BITS-1:0]   start_y,
  input  logic [COORD_BITS-1:0]   end_x,
  input  logic [COORD_BITS-1:0]   end_y,
  output logic [COORD_BITS-1:0]   x0,
  output logic [COORD_BITS-1:0]   y0,
  output logic [COORD_BITS-1:0]   major,
  output logic [COORD_BITS-1:0]   minor,
  output logic [COORD_BITS+2:0]   err0,
  output logic [COORD_BITS:0]     count,
  output lr_pkg::lr_flags_t       flags
);
  import lr_pkg::*;

  localparam int DW = COORD_BITS + 3;

  logic                  vertical;
  logic                  x_up;
  logic                  y_up;
  logic                  y_dn;
  logic                  swapped;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [COORD_BITS-1:0] lo;
  logic [COORD_BITS-1:0] hi;
  logic [COORD_BITS-1:0] span;

  always_comb begin
    vertical = (start_x == end_x);
    x_up     = (end_x > start_x);
    y_up     = (end_y > start_y);
    y_dn     = (end_y < start_y);
    dx       = x_up ? (end_x - start_x) : (start_x - end_x);
    dy       = y_up ? (end_y - start_y) : (start_y - end_y);
    swapped  = (dy > dx);
    lo       = y_up ? start_y : end_y;
    hi       = y_up ? end_y : start_y;
    span     = hi - lo;

    x0 = start_x;
    if (vertical) begin
      // A vertical span walks y upward with an error term that never turns
      // non-negative, so the x coordinate stays put.
      y0            = lo;
      major         = span;
      minor         = '0;
      err0          = {DW{1'b1}};
      count         = {1'b0, span} + {{COORD_BITS{1'b0}}, 1'b1};
      flags.swapped = 1'b1;
      flags.x_down  = 1'b0;
      flags.y_down  = 1'b0;
      flags.x_moves = 1'b0;
      flags.y_moves = 1'b1;
    end else begin
      y0            = start_y;
      major         = swapped ? dy : dx;
      minor         = swapped ? dx : dy;
      err0          = {{(DW-COORD_BITS-1){1'b0}}, minor, 1'b0}
                      - {{(DW-COORD_BITS){1'b0}}, major};
      count         = {1'b0, major};
      flags.swapped = swapped;
      flags.x_down  = !x_up;
      flags.y_down  = y_dn;
      flags.x_moves = 1'b1;
      flags.y_moves = y_up || y_dn;
    end
  end

endmodule

[design/lr_cmd_fifo.sv]
`timescale 1ns / 1ps

module lr_cmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      fill;

  assign full      = (fill == (AW+1)'(DEPTH));
  assign not_empty = (fill != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (AW+1)'(DEPTH)) else $error("command queue fill exceeds depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("push into a full command queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty) else $error("pop from an empty command queue");

endmodule

[design/lr_back.sv]
`timescale 1ns / 1ps

module lr_back #(
  parameter int COORD_BITS = 6
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  output logic                    cmd_pop,
  input  logic [COORD_BITS-1:0]   x0,
  input  logic [COORD_BITS-1:0]   y0,
  input  logic [COORD_BITS-1:0]   major,
  input  logic [COORD_BITS-1:0]   minor,
  input  logic [COORD_BITS+2:0]   err0,
  input  logic [COORD_BITS:0]     count,
  input  lr_pkg::lr_flags_t       flags,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [COORD_BITS-1:0]   pix_x,
  output logic [COORD_BITS-1:0]   pix_y,
  output logic                    m_tlast
);
  import lr_pkg::*;

  localparam int DW = COORD_BITS + 3;

  logic                  active;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic [DW-1:0]         error_term;
  logic [DW-1:0]         inc_lt;
  logic [DW-1:0]         inc_ge;
  logic [COORD_BITS:0]   pixels_left;
  lr_flags_t             step_flags;

  logic                  advance;
  logic                  finishing;
  logic                  err_ge;
  logic                  step_x;
  logic                  step_y;
  logic [COORD_BITS-1:0] cur_x_next;
  logic [COORD_BITS-1:0] cur_y_next;
  logic [DW-1:0]         error_term_next;

  always_comb begin
    advance   = active && (!m_tvalid || m_tready);
    finishing = advance && (pixels_left == (COORD_BITS+1)'(1));
    cmd_pop   = cmd_valid && (!active || finishing);
    err_ge    = !error_term[DW-1];
    step_x    = step_flags.x_moves && (!step_flags.swapped || err_ge);
    step_y    = step_flags.y_moves && (step_flags.swapped || err_ge);
    cur_x_next = cur_x;
    if (step_x) begin
      cur_x_next = step_flags.x_down ? cur_x - 1'b1 : cur_x + 1'b1;
    end
    cur_y_next = cur_y;
    if (step_y) begin
      cur_y_next = step_flags.y_down ? cur_y - 1'b1 : cur_y + 1'b1;
    end
    error_term_next = error_term + (err_ge ? inc_ge : inc_lt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd_pop) begin
        active <= 1'b1;
      end else if (finishing) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pix_x   <= cur_x;
      pix_y   <= cur_y;
      m_tlast <= (pixels_left == (COORD_BITS+1)'(1));
    end
    if (cmd_pop) begin
      cur_x       <= x0;
      cur_y       <= y0;
      error_term  <= err0;
      pixels_left <= count;
      step_flags  <= flags;
      inc_lt      <= {{(DW-COORD_BITS-1){1'b0}}, minor, 1'b0};
      inc_ge      <= {{(DW-COORD_BITS-1){1'b0}}, minor, 1'b0}
                     - {{(DW-COORD_BITS-1){1'b0}}, major, 1'b0};
    end else if (advance) begin
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      error_term  <= error_term_next;
      pixels_left <= pixels_left - 1'b1;
    end
  end

  a_active_has_work: assert property (@(posedge clk) disable iff (rst)
    active |-> (pixels_left != '0)) else $error("stepper active with no pixels left");

  a_last_marks_end: assert property (@(posedge clk) disable iff (rst)
    finishing |=> (m_tvalid && m_tlast)) else $error("final pixel not flagged as last");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && active) |-> finishing) else $error("command loaded over a running line");

endmodule

[design/line_rasterizer.sv]
`timescale 1ns / 1ps

// Line rasterizer: each input beat is one line request, and the block answers with
// a run of pixel beats, the last one marked by tlast. Equal start and end x give a
// vertical span from the lower y to the higher y, both ends included; any other
// line is stepped with Bresenham's error term from the start point for
// max(|dx|,|dy|) pixels, so the end point itself is not sent. A classifier works
// out deltas, direction and the first error term in the cycle a request is
// accepted and places it in a two-entry command queue; the pixel stepper drains
// that queue and sends one pixel per cycle while the output is taken; a line has
// up to 2^COORD_BITS pixels and consecutive lines follow with no gap. When the
// stepper is free, a request passes the command queue and the stepper's load
// before its first pixel is registered at the output. Input tdata bits above the
// coordinate fields are ignored.
module line_rasterizer #(
  parameter int COORD_BITS = 6
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // start_x, start_y, end_x, end_y from the lowest bit up, zero padded.
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]       s_tdata,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // pixel_x, pixel_y from the lowest bit up, zero padded.
  output logic [((2*COORD_BITS+7)/8)*8-1:0]       m_tdata,
  output logic                                    m_tlast
);
  import lr_pkg::*;

  localparam int CB      = COORD_BITS;
  localparam int DW      = CB + 3;
  localparam int OUT_W   = ((2*CB+7)/8)*8;
  localparam int FLAGS_W = $bits(lr_flags_t);
  localparam int CMD_W   = FLAGS_W + (CB+1) + DW + 4*CB;

  logic [CB-1:0]    f_x0;
  logic [CB-1:0]    f_y0;
  logic [CB-1:0]    f_major;
  logic [CB-1:0]    f_minor;
  logic [DW-1:0]    f_err0;
  logic [CB:0]      f_count;
  lr_flags_t        f_flags;

  logic [CMD_W-1:0] cmd_in;
  logic [CMD_W-1:0] cmd_out;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic             push;

  logic [CB-1:0]    b_x0;
  logic [CB-1:0]    b_y0;
  logic [CB-1:0]    b_major;
  logic [CB-1:0]    b_minor;
  logic [DW-1:0]    b_err0;
  logic [CB:0]      b_count;
  lr_flags_t        b_flags;
  logic [CB-1:0]    pix_x;
  logic [CB-1:0]    pix_y;

  lr_front #(.COORD_BITS(CB)) u_front (
    .start_x (s_tdata[CB-1:0]),
    .start_y (s_tdata[2*CB-1:CB]),
    .end_x   (s_tdata[3*CB-1:2*CB]),
    .end_y   (s_tdata[4*CB-1:3*CB]),
    .x0      (f_x0),
    .y0      (f_y0),
    .major   (f_major),
    .minor   (f_minor),
    .err0    (f_err0),
    .count   (f_count),
    .flags   (f_flags)
  );

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;
  assign cmd_in   = {f_flags, f_count, f_err0, f_minor, f_major, f_y0, f_x0};

  lr_cmd_fifo #(.WIDTH(CMD_W), .DEPTH(2)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_data   (cmd_in),
    .full      (q_full),
    .pop       (q_pop),
    .rd_data   (cmd_out),
    .not_empty (q_valid)
  );

  assign {b_flags, b_count, b_err0, b_minor, b_major, b_y0, b_x0} = cmd_out;

  lr_back #(.COORD_BITS(CB)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_pop   (q_pop),
    .x0        (b_x0),
    .y0        (b_y0),
    .major     (b_major),
    .minor     (b_minor),
    .err0      (b_err0),
    .count     (b_count),
    .flags     (b_flags),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .m_tlast   (m_tlast)
  );

  assign m_tdata = {{(OUT_W-2*CB){1'b0}}, pix_y, pix_x};

endmodule

[tb/sv/line_rasterizer_tb.sv]
`timescale 1ns / 1ps

localparam int CB = 6;

typedef struct packed {
  logic [CB-1:0] x;
  logic [CB-1:0] y;
  logic          last;
} pixel_t;

class pixel_scoreboard;
  pixel_t         pixel_q[$];
  int             errors;
  int             lines;
  int             vertical_lines;
  int             pixels_checked;
  logic [CB-1:0]  cur_x;
  logic [CB-1:0]  cur_y;
  logic [8:0]     err_term;
  logic [CB-1:0]  major_delta;
  logic [CB-1:0]  minor_delta;
  lr_pkg::lr_flags_t flags;

  function new();
    errors = 0;
    lines = 0;
    vertical_lines = 0;
    pixels_checked = 0;
    cur_x = '0;
    cur_y = '0;
    err_term = '0;
    major_delta = '0;
    minor_delta = '0;
    flags = '0;
  endfunction

  function void push_pixel(int x, int y, bit last);
    pixel_t p;
    p.x = x[CB-1:0];
    p.y = y[CB-1:0];
    p.last = last;
    pixel_q.push_back(p);
    cur_x = p.x;
    cur_y = p.y;
  endfunction

  // Works out the pixel run of one accepted line request.
  function void note_line(bit [CB-1:0] sx, bit [CB-1:0] sy, bit [CB-1:0] ex,
                          bit [CB-1:0] ey);
    int lo, hi, dx, dy, stx, sty, maj, mnr, d, x, y;
    bit swapped;
    lines++;
    if (sx == ex) begin
      vertical_lines++;
      lo = (sy < ey) ? sy : ey;
      hi = (sy < ey) ? ey : sy;
      major_delta = CB'(hi - lo);
      minor_delta = '0;
      flags = '0;
      flags.y_moves = 1'b1;
      err_term = '0;
      for (int yy = lo; yy <= hi; yy++) push_pixel(sx, yy, yy == hi);
      return;
    end
    dx = (ex > sx) ? ex - sx : sx - ex;
    dy = (ey > sy) ? ey - sy : sy - ey;
    stx = (ex > sx) ? 1 : -1;
    sty = (ey > sy) ? 1 : ((ey < sy) ? -1 : 0);
    swapped = dy > dx;
    maj = swapped ? dy : dx;
    mnr = swapped ? dx : dy;
    d = 2 * mnr - maj;
    x = sx;
    y = sy;
    major_delta = CB'(maj);
    minor_delta = CB'(mnr);
    flags.swapped = swapped;
    flags.x_down = stx < 0;
    flags.y_down = sty < 0;
    flags.x_moves = 1'b1;
    flags.y_moves = sty != 0;
    for (int i = 0; i < maj; i++) begin
      push_pixel(x, y, i == maj - 1);
      if (d >= 0) begin
        d -= 2 * maj;
        if (swapped) x += stx;
        else y += sty;
      end
      d += 2 * mnr;
      if (swapped) y += sty;
      else x += stx;
    end
    err_term = d[8:0];
  endfunction

  function void check_pixel(logic [CB-1:0] x, logic [CB-1:0] y, logic last);
    pixel_t exp_px;
    pixels_checked++;
    if (pixel_q.size() == 0) begin
      $error("Unexpected pixel beat: x=%0d y=%0d last=%0b", x, y, last);
      errors++;
      return;
    end
    exp_px = pixel_q.pop_front();
    if (x !== exp_px.x) begin
      $error("pixel_x: expected %0d, actual %0d", exp_px.x, x);
      errors++;
    end
    if (y !== exp_px.y) begin
      $error("pixel_y: expected %0d, actual %0d", exp_px.y, y);
      errors++;
    end
    if (last !== exp_px.last) begin
      $error("last_pixel: expected %0b, actual %0b", exp_px.last, last);
      errors++;
    end
  endfunction

  function int pending();
    return pixel_q.size();
  endfunction
endclass

module line_rasterizer_tb;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [23:0]   s_tdata = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [15:0]   m_tdata;
  logic          m_tlast;

  int            tx_idle_pct = 0;
  int            rx_stall_pct = 0;
  logic          hold_req = 1'b0;
  logic          hold_taken = 1'b0;
  int            hold_left = 0;

  pixel_scoreboard sb = new();

  line_rasterizer #(.COORD_BITS(CB)) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The receiver holds off for a long stretch once when asked, so the block fills up.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= 400;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_pixel(m_tdata[CB-1:0], m_tdata[2*CB-1:CB], m_tlast);
    end
  end

  task automatic send_line(input bit [CB-1:0] sx, input bit [CB-1:0] sy,
                           input bit [CB-1:0] ex, input bit [CB-1:0] ey);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {ey, ex, sy, sx};
    do @(posedge clk); while (!s_tready);
    sb.note_line(sx, sy, ex, ey);
  endtask

  task automatic send_random_line();
    bit [CB-1:0] sx, sy, ex, ey;
    int kind;
    sx = CB'($urandom);
    sy = CB'($urandom);
    ex = CB'($urandom);
    ey = CB'($urandom);
    kind = $urandom_range(9);
    if (kind < 2) begin
      ex = sx;
    end else if (kind < 5) begin
      ex = CB'(sx + $urandom_range(7) - 3);
      ey = CB'(sy + $urandom_range(7) - 3);
    end else if (kind == 5) begin
      ey = sy;
    end
    send_line(sx, sy, ex, ey);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int count);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (count) send_random_line();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_line(0, 0, 0, 0);
    send_line(63, 63, 63, 63);
    send_line(5, 0, 5, 63);
    send_line(40, 63, 40, 0);
    send_line(0, 0, 63, 0);
    send_line(63, 63, 0, 63);
    send_line(0, 0, 63, 63);
    send_line(63, 0, 0, 63);
    send_line(0, 63, 63, 0);
    send_line(63, 63, 0, 0);
    send_line(10, 0, 11, 63);
    send_line(11, 63, 10, 0);
    send_line(0, 10, 63, 11);
    send_line(63, 11, 0, 10);
    send_line(1, 1, 2, 1);
    send_line(2, 5, 1, 5);
    send_line(20, 20, 21, 21);
    send_line(20, 20, 19, 22);
    send_line(0, 0, 1, 63);
    send_line(63, 63, 62, 0);
    send_line(7, 30, 50, 42);
    send_line(42, 21, 21, 42);

    run_phase(0, 0, 75);
    run_phase(59, 0, 75);
    run_phase(0, 59, 75);
    run_phase(17, 17, 75);

    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_req <= 1'b1;
    repeat (30) send_random_line();

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Covered %0d line requests (%0d vertical spans) and %0d pixel beats,",
             sb.lines, sb.vertical_lines, sb.pixels_checked);
    $display("with sender gaps, receiver stalls, both, and one long output hold-off.");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
